### rtl/cgs_pkg.sv
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared constants, types and codes of the Sobel / Canny gradient stage.
// ----------------------------------------------------------------------------
package cgs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 17;
  localparam int POS_W      = ROW_W + 1;
  localparam int DIM_W      = 11;
  localparam int HGT_W      = 16;
  localparam int MAG_W      = 11;
  localparam int GRAD_W     = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [ROW_W-1:0] ROW_LIMIT = 17'd131071;
  localparam logic [DIM_W-1:0] MIN_DIM   = 11'd3;
  localparam logic [DIM_W-1:0] MAX_DIM   = 11'(MAX_WIDTH);

  // Q16 tangents of 22.5 and 67.5 degrees
  localparam logic signed [32:0] TAN_22_5_Q16 = 33'sd27146;
  localparam logic signed [32:0] TAN_67_5_Q16 = 33'sd158218;

  // reciprocal of three for the gray average, 11 fraction bits
  localparam logic [9:0] THIRD_Q11 = 10'd683;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 8'd3;

  // input op codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_PAD   = 1'b1;

  // strength codes
  localparam logic [1:0] STR_NONE   = 2'd0;
  localparam logic [1:0] STR_WEAK   = 2'd1;
  localparam logic [1:0] STR_STRONG = 2'd2;

  // direction codes
  localparam logic [1:0] DIR_0   = 2'd0;
  localparam logic [1:0] DIR_45  = 2'd1;
  localparam logic [1:0] DIR_90  = 2'd2;
  localparam logic [1:0] DIR_135 = 2'd3;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] scol;
    logic [7:0]       gray;
    logic             sobel_zero;
    logic             center_valid;
    logic             border;
  } cgs_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SOBEL,
    BK_SQUARE,
    BK_ROOT_INIT,
    BK_ROOT,
    BK_GRAD,
    BK_EMIT
  } cgs_bk_state_t;

endpackage

### rtl/cgs_if.sv
// ----------------------------------------------------------------------------
// cgs_if
// Valid/ready channels of the gradient stage: pixels, results, configuration.
// ----------------------------------------------------------------------------
interface cgs_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic       frame_start;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, op, frame_start, red, green, blue, input ready);
  modport sink   (input valid, op, frame_start, red, green, blue, output ready);
endinterface

interface cgs_out_if;
  logic                     valid;
  logic                     ready;
  logic                     center_valid;
  logic                     border;
  logic [cgs_pkg::MAG_W-1:0] magnitude;
  logic [1:0]               strength;
  logic [1:0]               direction;
  logic                     keep;

  modport source (output valid, center_valid, border, magnitude, strength, direction, keep,
                  input ready);
  modport sink   (input valid, center_valid, border, magnitude, strength, direction, keep,
                  output ready);
endinterface

interface cgs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cgs_pkg::CFG_IDX_W-1:0]  index;
  logic [cgs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sobel_canny_gradient_stage.sv
// ----------------------------------------------------------------------------
// sobel_canny_gradient_stage
// Sobel gradient, magnitude, edge class, direction and non-maximum
// suppression over an RGB raster stream.
// ----------------------------------------------------------------------------
// Each input beat yields one result beat for the pixel two rows and two
// columns behind it; pad beats push the last rows out. The front takes a
// beat per cycle, while the queue is not full, into a four-entry job
// queue; the back runs one job at a time, held by any output stall, paced
// by the 11-step iterative square root and the single-port line buffers,
// and pops no new job until the last result is loaded. Configuration writes
// are always ready and must be made while no result is outstanding. Line
// buffers have no reset; entries never written only feed border positions.
module sobel_canny_gradient_stage (
  input  logic       clk,
  input  logic       rst_n,
  cgs_in_if.sink     in_ch,
  cgs_out_if.source  out_ch,
  cgs_cfg_if.sink    cfg_ch
);
  import cgs_pkg::*;

  logic [DIM_W-1:0] low_threshold_r, high_threshold_r, image_width_r;
  logic [HGT_W-1:0] image_height_r;
  logic [DIM_W-1:0] width_eff;
  logic [HGT_W-1:0] height_eff;

  logic     q_push, q_full, q_pop, q_empty;
  cgs_job_t q_job, q_head;

  assign cfg_ch.ready = 1'b1;

  // capture register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_threshold_r  <= 11'd70;
      high_threshold_r <= 11'd200;
      image_width_r    <= 11'd640;
      image_height_r   <= 16'd480;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_LOW_THRESHOLD:  low_threshold_r  <= cfg_ch.data[DIM_W-1:0];
        REG_HIGH_THRESHOLD: high_threshold_r <= cfg_ch.data[DIM_W-1:0];
        REG_IMAGE_WIDTH:    image_width_r    <= cfg_ch.data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   image_height_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // clamp frame size
  always_comb begin
    if (image_width_r < MIN_DIM)      width_eff = MIN_DIM;
    else if (image_width_r > MAX_DIM) width_eff = MAX_DIM;
    else                              width_eff = image_width_r;
    height_eff = (image_height_r < 16'd3) ? 16'd3 : image_height_r;
  end

  cgs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .width  (width_eff),
    .height (height_eff),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  cgs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  cgs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .low_threshold  (low_threshold_r),
    .high_threshold (high_threshold_r),
    .out_ch         (out_ch)
  );

endmodule

### rtl/cgs_front.sv
// ----------------------------------------------------------------------------
// cgs_front
// Accept pixel beats, track raster position, form gray and classify the
// Sobel and suppression centers of each beat into a job.
// ----------------------------------------------------------------------------
module cgs_front (
  input  logic                         clk,
  input  logic                         rst_n,
  cgs_in_if.sink                       in_ch,
  input  logic [cgs_pkg::DIM_W-1:0]    width,
  input  logic [cgs_pkg::HGT_W-1:0]    height,
  input  logic                         q_full,
  output logic                         q_push,
  output cgs_pkg::cgs_job_t            q_job
);
  import cgs_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic [COL_W-1:0] c0, c, sc, cc;
  logic [ROW_W-1:0] r0, r;
  logic [DIM_W-1:0] c_inc;
  logic signed [POS_W-1:0] sr, cr, hs;
  logic [9:0]  sum;
  logic [19:0] prod;
  logic [DIM_W-1:0] wm1;

  // position of this beat and of its two lagging centers
  always_comb begin
    wm1 = width - 11'd1;
    c0  = in_ch.frame_start ? '0 : col_r;
    r0  = in_ch.frame_start ? '0 : row_r;
    if ({1'b0, c0} >= width) begin
      c = '0;
      r = (r0 == ROW_LIMIT) ? r0 : r0 + 17'd1;
    end else begin
      c = c0;
      r = r0;
    end
    if (c != '0) begin
      sr = $signed({1'b0, r}) - 18'sd1;
      sc = c - 10'd1;
    end else begin
      sr = $signed({1'b0, r}) - 18'sd2;
      sc = wm1[COL_W-1:0];
    end
    if (sc != '0) begin
      cr = sr - 18'sd1;
      cc = sc - 10'd1;
    end else begin
      cr = sr - 18'sd2;
      cc = wm1[COL_W-1:0];
    end
    hs = $signed({2'b00, height});
    // advance the counters past this beat
    c_inc = {1'b0, c} + 11'd1;
    if (c_inc >= width) begin
      col_nxt = '0;
      row_nxt = (r == ROW_LIMIT) ? r : r + 17'd1;
    end else begin
      col_nxt = c_inc[COL_W-1:0];
      row_nxt = r;
    end
    // gray = sum / 3 by reciprocal multiply
    sum  = {2'b00, in_ch.red} + {2'b00, in_ch.green} + {2'b00, in_ch.blue};
    prod = sum * THIRD_Q11;
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_job.col  = c;
    q_job.scol = sc;
    q_job.gray = (in_ch.op == OP_PAD) ? 8'd0 : prod[18:11];
    q_job.sobel_zero = (sr <= 18'sd0) || (sr >= hs - 18'sd1) || (sc == '0) ||
                       ({1'b0, sc} == wm1);
    q_job.center_valid = (cr >= 18'sd0) && (cr < hs);
    q_job.border = (cr == 18'sd0) || (cr == hs - 18'sd1) || (cc == '0) ||
                   ({1'b0, cc} == wm1);
  end

  // hold position between beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (q_push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### rtl/cgs_queue.sv
// ----------------------------------------------------------------------------
// cgs_queue
// Small job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module cgs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cgs_pkg::cgs_job_t push_job,
  output logic              full,
  input  logic              pop,
  output cgs_pkg::cgs_job_t head,
  output logic              empty
);
  import cgs_pkg::*;

  cgs_job_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // store the job on push
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/cgs_back.sv
// ----------------------------------------------------------------------------
// cgs_back
// Run one job: line buffers, Sobel, iterative square root, direction,
// thresholds and non-maximum suppression; hold the result beat.
// ----------------------------------------------------------------------------
module cgs_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  cgs_pkg::cgs_job_t            q_head,
  output logic                         q_pop,
  input  logic [cgs_pkg::DIM_W-1:0]    low_threshold,
  input  logic [cgs_pkg::DIM_W-1:0]    high_threshold,
  cgs_out_if.source                    out_ch
);
  import cgs_pkg::*;

  cgs_bk_state_t state_r, state_nxt;
  cgs_job_t      job_r;

  logic [7:0]        gl0 [MAX_WIDTH];
  logic [7:0]        gl1 [MAX_WIDTH];
  logic [GRAD_W-1:0] gr0 [MAX_WIDTH];
  logic [GRAD_W-1:0] gr1 [MAX_WIDTH];
  logic [7:0]        gl0_q_r, gl1_q_r;
  logic [GRAD_W-1:0] gr0_q_r, gr1_q_r;

  logic [7:0]        gw_r [3][3];
  logic [GRAD_W-1:0] dw_r [3][3];

  logic signed [11:0] gx_r, gy_r;
  logic [20:0]        sqx_r, sqy_r;
  logic [10:0]        y_r;
  logic signed [32:0] p1_r, p2_r;
  logic [1:0]         dir_r;
  logic [21:0]        v_r, res_r, bit_r;

  logic               load_out, emit_done;
  logic               out_valid_r, out_cv_r, out_border_r, out_keep_r;
  logic [MAG_W-1:0]   out_mag_r;
  logic [1:0]         out_str_r, out_dir_r;

  // next state and handshake
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    emit_done = !out_valid_r || out_ch.ready;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = BK_READ;
        end
      end
      BK_READ:      state_nxt = BK_SOBEL;
      BK_SOBEL:     state_nxt = BK_SQUARE;
      BK_SQUARE:    state_nxt = BK_ROOT_INIT;
      BK_ROOT_INIT: state_nxt = BK_ROOT;
      BK_ROOT: begin
        if (bit_r[1:0] != 2'b00 || bit_r == 22'd1) begin
          if (bit_r == 22'd1) state_nxt = BK_GRAD;
        end
      end
      BK_GRAD:      state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (emit_done) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default:      state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  // line buffers: read on pop, write once the job has its values
  always_ff @(posedge clk) begin
    if (q_pop) begin
      gl0_q_r <= gl0[q_head.col];
      gl1_q_r <= gl1[q_head.col];
    end
    if (state_r == BK_READ) begin
      gl1[job_r.col] <= gl0_q_r;
      gl0[job_r.col] <= job_r.gray;
    end
  end

  logic [GRAD_W-1:0] packed_c;
  logic [MAG_W-1:0]  mag_c;
  logic [1:0]        str_c;

  always_comb begin
    mag_c = res_r[MAG_W-1:0];
    if (mag_c > high_threshold)     str_c = STR_STRONG;
    else if (mag_c > low_threshold) str_c = STR_WEAK;
    else                            str_c = STR_NONE;
    packed_c = job_r.sobel_zero ? '0 : {dir_r, str_c, mag_c};
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      gr0_q_r <= gr0[q_head.scol];
      gr1_q_r <= gr1[q_head.scol];
    end
    if (state_r == BK_GRAD) begin
      gr1[job_r.scol] <= gr0_q_r;
      gr0[job_r.scol] <= packed_c;
    end
  end

  // Sobel taps and squares
  logic [9:0]         xp, xn, yp, yn;
  logic signed [11:0] gx_c, gy_c, xf_c;
  logic [10:0]        yf_c;
  logic signed [23:0] sqx_c, sqy_c;
  logic signed [32:0] xf_ext;

  always_comb begin
    xp = {2'b00, gw_r[0][2]} + {1'b0, gw_r[1][2], 1'b0} + {2'b00, gw_r[2][2]};
    xn = {2'b00, gw_r[0][0]} + {1'b0, gw_r[1][0], 1'b0} + {2'b00, gw_r[2][0]};
    yp = {2'b00, gw_r[2][0]} + {1'b0, gw_r[2][1], 1'b0} + {2'b00, gw_r[2][2]};
    yn = {2'b00, gw_r[0][0]} + {1'b0, gw_r[0][1], 1'b0} + {2'b00, gw_r[0][2]};
    gx_c = $signed({2'b00, xp}) - $signed({2'b00, xn});
    gy_c = $signed({2'b00, yp}) - $signed({2'b00, yn});
    sqx_c = gx_r * gx_r;
    sqy_c = gy_r * gy_r;
    // fold into the upper half plane
    xf_c = gy_r[11] ? -gx_r : gx_r;
    yf_c = gy_r[11] ? 11'(-gy_r) : gy_r[10:0];
    xf_ext = {{21{xf_c[11]}}, xf_c};
  end

  // direction from the Q16 tangent comparisons
  logic signed [32:0] ys_c;
  logic [1:0]         dir_c;

  always_comb begin
    ys_c = $signed({6'b0, y_r, 16'b0});
    if (ys_c <= p1_r)       dir_c = DIR_0;
    else if (ys_c <= p2_r)  dir_c = DIR_45;
    else if (ys_c >= -p2_r) dir_c = DIR_90;
    else if (ys_c >= -p1_r) dir_c = DIR_135;
    else                    dir_c = DIR_0;
  end

  // one square root step per cycle
  logic [21:0] trial_c;
  assign trial_c = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          gw_r[k][j] <= '0;
          dw_r[k][j] <= '0;
        end
      end
    end else begin
      if (state_r == BK_READ) begin
        for (int k = 0; k < 3; k++) begin
          gw_r[k][0] <= gw_r[k][1];
          gw_r[k][1] <= gw_r[k][2];
        end
        gw_r[0][2] <= gl1_q_r;
        gw_r[1][2] <= gl0_q_r;
        gw_r[2][2] <= job_r.gray;
      end
      if (state_r == BK_GRAD) begin
        for (int k = 0; k < 3; k++) begin
          dw_r[k][0] <= dw_r[k][1];
          dw_r[k][1] <= dw_r[k][2];
        end
        dw_r[0][2] <= gr1_q_r;
        dw_r[1][2] <= gr0_q_r;
        dw_r[2][2] <= packed_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_head;
    case (state_r)
      BK_SOBEL: begin
        gx_r <= gx_c;
        gy_r <= gy_c;
      end
      BK_SQUARE: begin
        sqx_r <= sqx_c[20:0];
        sqy_r <= sqy_c[20:0];
        y_r   <= yf_c;
        p1_r  <= xf_ext * TAN_22_5_Q16;
        p2_r  <= xf_ext * TAN_67_5_Q16;
      end
      BK_ROOT_INIT: begin
        v_r   <= {1'b0, sqx_r} + {1'b0, sqy_r};
        res_r <= '0;
        bit_r <= 22'd1 << 20;
        dir_r <= dir_c;
      end
      BK_ROOT: begin
        if (v_r >= trial_c) begin
          v_r   <= v_r - trial_c;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      default: ;
    endcase
  end

  // suppression along the quantized direction
  logic [GRAD_W-1:0] ctr_c, n1_c, n2_c;
  logic [MAG_W-1:0]  cmag_c;

  always_comb begin
    ctr_c  = dw_r[1][1];
    cmag_c = ctr_c[MAG_W-1:0];
    case (ctr_c[14:13])
      DIR_0: begin
        n1_c = dw_r[1][2];
        n2_c = dw_r[1][0];
      end
      DIR_135: begin
        n1_c = dw_r[0][2];
        n2_c = dw_r[2][0];
      end
      DIR_90: begin
        n1_c = dw_r[2][1];
        n2_c = dw_r[0][1];
      end
      default: begin
        n1_c = dw_r[2][2];
        n2_c = dw_r[0][0];
      end
    endcase
  end

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_cv_r     <= job_r.center_valid;
      out_border_r <= 1'b0;
      out_mag_r    <= '0;
      out_str_r    <= STR_NONE;
      out_dir_r    <= DIR_0;
      out_keep_r   <= 1'b0;
      if (job_r.center_valid) begin
        if (job_r.border) begin
          out_border_r <= 1'b1;
          out_keep_r   <= 1'b1;
        end else begin
          out_mag_r  <= cmag_c;
          out_str_r  <= ctr_c[12:11];
          out_dir_r  <= ctr_c[14:13];
          out_keep_r <= (cmag_c >= n1_c[MAG_W-1:0]) && (cmag_c >= n2_c[MAG_W-1:0]);
        end
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.center_valid = out_cv_r;
  assign out_ch.border       = out_border_r;
  assign out_ch.magnitude    = out_mag_r;
  assign out_ch.strength     = out_str_r;
  assign out_ch.direction    = out_dir_r;
  assign out_ch.keep         = out_keep_r;

endmodule
